/* src/b2bcd_pkg.sv */
// package: shared constants, control struct and digit adjust function
`default_nettype none
package b2bcd_pkg;

  localparam int B2BCD_WIDTH = 64;
  localparam int B2BCD_BYTES = 10;

  typedef struct packed {
    logic clear;
    logic dabble;
    logic bit_in;
    logic shift_byte;
  } b2bcd_ctl_t;

  function automatic logic [3:0] add3(input logic [3:0] d);
    logic [3:0] r;
    r = (d >= 4'd5) ? d + 4'd3 : d;
    return r;
  endfunction

endpackage
`default_nettype wire

/* src/b2bcd_if.sv */
// interfaces: binary request channel and bcd byte channel
`default_nettype none
interface b2bcd_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;
  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

interface b2bcd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] bcd_pair;
  logic       last;
  modport source (output valid, output bcd_pair, output last, input ready);
  modport sink (input valid, input bcd_pair, input last, output ready);
endinterface
`default_nettype wire

/* src/b2bcd_digits.sv */
// bcd digit row: add-3 and shift one bit per cycle, byte shift for output
`default_nettype none
module b2bcd_digits #(
  parameter int NBYTES = b2bcd_pkg::B2BCD_BYTES
) (
  input  wire logic                   clk,
  input  wire b2bcd_pkg::b2bcd_ctl_t  ctl,
  output logic [7:0]                  top_byte
);
  import b2bcd_pkg::*;

  localparam int NDIG = 2 * NBYTES;

  logic [3:0] dig [NDIG];
  logic [3:0] adj [NDIG];

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      adj[i] = add3(dig[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      for (int i = 0; i < NDIG; i++) begin
        dig[i] <= 4'd0;
      end
    end else if (ctl.dabble) begin
      dig[0] <= {adj[0][2:0], ctl.bit_in};
      for (int i = 1; i < NDIG; i++) begin
        dig[i] <= {adj[i][2:0], adj[i-1][3]};
      end
    end else if (ctl.shift_byte) begin
      dig[0] <= 4'd0;
      dig[1] <= 4'd0;
      for (int i = 2; i < NDIG; i++) begin
        dig[i] <= dig[i-2];
      end
    end
  end

  assign top_byte = {dig[NDIG-1], dig[NDIG-2]};

endmodule
`default_nettype wire

/* src/b2bcd_ctrl.sv */
// sequencer: bit-serial input shifting, byte output with leading zero drop
`default_nettype none
module b2bcd_ctrl #(
  parameter int WIDTH  = b2bcd_pkg::B2BCD_WIDTH,
  parameter int NBYTES = b2bcd_pkg::B2BCD_BYTES
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  b2bcd_in_if.sink                    bin,
  b2bcd_out_if.source                 bcd,
  input  wire logic [7:0]             top_byte,
  output b2bcd_pkg::b2bcd_ctl_t       ctl
);
  import b2bcd_pkg::*;

  localparam int CW = $clog2(WIDTH + 1);
  localparam int BW = $clog2(NBYTES + 1);

  typedef enum logic [1:0] {IDLE, CONV, EMIT} state_t;

  state_t           state;
  logic [WIDTH-1:0] work;
  logic [CW-1:0]    cnt;
  logic [BW-1:0]    left;
  logic             started;
  logic             out_valid;
  logic [7:0]       pair;
  logic             last_r;

  logic fire_in;
  logic can_load;
  logic skip;
  logic load;

  always_comb begin
    fire_in  = bin.valid && (state == IDLE);
    can_load = !out_valid || bcd.ready;
    skip     = (state == EMIT) && !started && (top_byte == 8'd0) && (left != BW'(1));
    load     = (state == EMIT) && can_load && !skip;
    ctl.clear      = fire_in;
    ctl.dabble     = (state == CONV);
    ctl.bit_in     = work[WIDTH-1];
    ctl.shift_byte = skip || load;
  end

  assign bin.ready    = (state == IDLE);
  assign bcd.valid    = out_valid;
  assign bcd.bcd_pair = pair;
  assign bcd.last     = last_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
      started   <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (bcd.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (fire_in) begin
            work  <= bin.value[WIDTH-1:0];
            cnt   <= CW'(WIDTH);
            state <= CONV;
          end
        end
        CONV: begin
          work <= {work[WIDTH-2:0], 1'b0};
          cnt  <= cnt - CW'(1);
          if (cnt == CW'(1)) begin
            left    <= BW'(NBYTES);
            started <= 1'b0;
            state   <= EMIT;
          end
        end
        EMIT: begin
          if (skip) begin
            left <= left - BW'(1);
          end else if (load) begin
            pair      <= top_byte;
            last_r    <= (left == BW'(1));
            started   <= 1'b1;
            left      <= left - BW'(1);
            if (left == BW'(1)) begin
              state <= IDLE;
            end
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    (load && (left == BW'(1))) |=> (state == IDLE && last_r && out_valid))
    else $error("last byte did not end the run");

  a_conv_count: assert property (@(posedge clk) disable iff (rst)
    fire_in |=> (state == CONV && cnt == CW'(WIDTH)))
    else $error("conversion count not loaded");

  a_bcd_digits: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pair[7:4] <= 4'd9 && pair[3:0] <= 4'd9))
    else $error("result byte holds a non-decimal digit");

  a_left_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == EMIT) |-> (left != BW'(0)))
    else $error("byte count ran out during output");

endmodule
`default_nettype wire

/* src/binary_to_bcd_double_dabble.sv */
// top level: binary to packed bcd converter, shift and add 3
// a taken request is shifted into the digit row bit by bit in CONV, then EMIT drops leading zero
// bytes and loads the rest into the output register; the digit row takes one bit per cycle and
// the output gives one byte per cycle while the receiver is ready
// one request at a time; the next is taken while the last byte waits in the output register
// reset: rst synchronous active high, returns to idle with no byte pending
`default_nettype none
module binary_to_bcd_double_dabble #(
  parameter int WIDTH = b2bcd_pkg::B2BCD_WIDTH
) (
  input  wire logic   clk,
  input  wire logic   rst,
  b2bcd_in_if.sink    bin,
  b2bcd_out_if.source bcd
);
  import b2bcd_pkg::*;

  localparam int NDIG   = (WIDTH * 301) / 1000 + 1;
  localparam int NBYTES = (NDIG + 1) / 2;

  b2bcd_ctl_t ctl;
  logic [7:0] top_byte;

  b2bcd_ctrl #(
    .WIDTH  (WIDTH),
    .NBYTES (NBYTES)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .bin      (bin),
    .bcd      (bcd),
    .top_byte (top_byte),
    .ctl      (ctl)
  );

  b2bcd_digits #(
    .NBYTES (NBYTES)
  ) u_digits (
    .clk      (clk),
    .ctl      (ctl),
    .top_byte (top_byte)
  );

endmodule
`default_nettype wire

/* tb/binary_to_bcd_double_dabble_tb.sv */
// testbench: random and directed binary requests checked against a shift and add 3 predictor
`default_nettype none
module binary_to_bcd_double_dabble_tb;

  localparam int WIDTH = b2bcd_pkg::B2BCD_WIDTH;
  localparam logic [63:0] WIDTH_MASK = {64{1'b1}} >> (64 - WIDTH);
  localparam int RANDOM_REQUESTS = 365;

  typedef struct packed {
    logic [7:0] bcd_pair;
    logic       last;
  } bcd_byte_t;

  logic clk;
  logic rst;

  b2bcd_in_if  bin_if ();
  b2bcd_out_if bcd_if ();

  logic [63:0] pending_values_q[$];
  bcd_byte_t   bcd_byte_q[$];
  int unsigned requests_sent;
  int unsigned total_requests;
  int unsigned mismatch_count;

  binary_to_bcd_double_dabble #(
    .WIDTH(WIDTH)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .bin(bin_if),
    .bcd(bcd_if)
  );

  always #10 clk = ~clk;

  // sender idles 11 and receiver 70 in a hundred, then swapped, then no idling
  function automatic int unsigned stall_pct(input bit is_sender);
    if (requests_sent < total_requests / 3) begin
      return is_sender ? 11 : 70;
    end else if (requests_sent < 2 * total_requests / 3) begin
      return is_sender ? 70 : 11;
    end
    return 0;
  endfunction

  task automatic predict_bcd_bytes(input logic [63:0] value);
    logic [63:0] bits;
    logic [79:0] digits;
    int          top;
    bits   = value & WIDTH_MASK;
    digits = '0;
    top    = 0;
    for (int i = 63; i >= 0; i--) begin
      for (int d = 0; d < 20; d++) begin
        if (digits[d*4 +: 4] >= 4'd5) begin
          digits[d*4 +: 4] = digits[d*4 +: 4] + 4'd3;
        end
      end
      digits = {digits[78:0], bits[i]};
    end
    for (int k = 9; k > 0; k--) begin
      if (top == 0 && digits[k*8 +: 8] != 8'h00) begin
        top = k;
      end
    end
    for (int k = top; k >= 0; k--) begin
      bcd_byte_q.push_back('{bcd_pair: digits[k*8 +: 8], last: (k == 0)});
    end
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      bin_if.valid <= 1'b0;
    end else begin
      if (bin_if.valid && bin_if.ready) begin
        predict_bcd_bytes(bin_if.value);
        requests_sent <= requests_sent + 1;
      end
      if (!bin_if.valid || bin_if.ready) begin
        if (pending_values_q.size() > 0 && $urandom_range(99) >= stall_pct(1'b1)) begin
          bin_if.valid <= 1'b1;
          bin_if.value <= pending_values_q.pop_front();
        end else begin
          bin_if.valid <= 1'b0;
        end
      end
    end
  end

  // bcd byte monitor
  always @(posedge clk) begin
    bcd_byte_t exp_byte;
    if (rst) begin
      bcd_if.ready <= 1'b0;
    end else begin
      if (bcd_if.valid && bcd_if.ready) begin
        if (bcd_byte_q.size() == 0) begin
          $display("%0t: unexpected bcd byte %h last %b", $time, bcd_if.bcd_pair, bcd_if.last);
          mismatch_count <= mismatch_count + 1;
        end else begin
          exp_byte = bcd_byte_q.pop_front();
          if (bcd_if.bcd_pair !== exp_byte.bcd_pair || bcd_if.last !== exp_byte.last) begin
            $display("%0t: expected bcd_pair %h last %b, got bcd_pair %h last %b", $time,
                     exp_byte.bcd_pair, exp_byte.last, bcd_if.bcd_pair, bcd_if.last);
            mismatch_count <= mismatch_count + 1;
          end
        end
      end
      bcd_if.ready <= ($urandom_range(99) >= stall_pct(1'b0));
    end
  end

  initial begin
    logic [63:0] rnd;
    logic [63:0] pow10;
    clk            = 1'b0;
    rst            = 1'b1;
    bin_if.valid   = 1'b0;
    bin_if.value   = '0;
    bcd_if.ready   = 1'b0;
    requests_sent  = 0;
    mismatch_count = 0;

    // extremes, digit boundaries and alternating bit patterns
    pending_values_q.push_back(64'd0);
    pending_values_q.push_back(64'd1);
    pending_values_q.push_back(64'd5);
    pending_values_q.push_back(64'd9);
    pending_values_q.push_back(64'd10);
    pending_values_q.push_back(64'd99);
    pending_values_q.push_back(64'd100);
    pending_values_q.push_back(64'd255);
    pending_values_q.push_back(64'hFFFF_FFFF);
    pending_values_q.push_back(64'd1_000_000_000_000_000_000);
    pending_values_q.push_back(64'd9_999_999_999_999_999_999);
    pending_values_q.push_back(64'd10_000_000_000_000_000_000);
    pending_values_q.push_back(64'h8000_0000_0000_0000);
    pending_values_q.push_back(64'h5555_5555_5555_5555);
    pending_values_q.push_back(64'hAAAA_AAAA_AAAA_AAAA);
    pending_values_q.push_back(64'hFFFF_FFFF_FFFF_FFFF);
    pending_values_q.push_back(64'd0);

    repeat (RANDOM_REQUESTS) begin
      rnd = {$urandom, $urandom};
      case ($urandom_range(3))
        0: rnd = rnd >> $urandom_range(63);
        1: rnd = rnd >> $urandom_range(56, 63);
        2: begin
          pow10 = 64'd1;
          repeat ($urandom_range(19)) pow10 = pow10 * 64'd10;
          rnd = pow10 - 64'd1 + $urandom_range(2);
        end
        default: ;
      endcase
      pending_values_q.push_back(rnd);
    end
    total_requests = pending_values_q.size();

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (requests_sent < total_requests) @(posedge clk);
    while (bcd_byte_q.size() > 0) @(posedge clk);
    repeat (WIDTH + 20) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    if (bcd_byte_q.size() > 0) begin
      $display("%0t: %0d bcd bytes never arrived", $time, bcd_byte_q.size());
    end
    $display("Mismatches found");
    $finish;
  end

endmodule
`default_nettype wire

/* sim.f */
src/b2bcd_pkg.sv
src/b2bcd_if.sv
src/b2bcd_digits.sv
src/b2bcd_ctrl.sv
src/binary_to_bcd_double_dabble.sv
tb/binary_to_bcd_double_dabble_tb.sv
